// ===== hw/rtl/cst_pkg.sv =====
// Package for the connection slot table: command and status codes, register
// indexes and the structs passed along the chain of slot cells.
// No dependencies.
package cst_pkg;

	localparam int CMD_W      = 3;
	localparam int SLOT_W     = 4;
	localparam int FIELD_KEY_W = 32;
	localparam int FIELD_ST_W = 3;
	localparam int STATUS_W   = 2;
	localparam int LIVE_W     = 5;
	localparam int TSIZE_W    = 5;
	localparam int AUTH_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int SLOT_IDX_W = 6;
	localparam int LIM_W      = 7;

	localparam logic [CMD_W-1:0] OP_ADD        = 3'd0;
	localparam logic [CMD_W-1:0] OP_REMOVE     = 3'd1;
	localparam logic [CMD_W-1:0] OP_BIND       = 3'd2;
	localparam logic [CMD_W-1:0] OP_SET_STATE  = 3'd3;
	localparam logic [CMD_W-1:0] OP_FIND       = 3'd4;
	localparam logic [CMD_W-1:0] OP_FIND_OTHER = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AUTHED_CODE = 2'd1;

	typedef struct packed {
		logic [CMD_W-1:0]  op;
		logic [SLOT_W-1:0] slot;
		logic [LIM_W-1:0]  lim;
	} cst_cmd_t;

	typedef struct packed {
		logic                  tok;
		logic                  hit;
		logic [SLOT_IDX_W-1:0] idx;
		logic                  tgt_occ;
	} cst_link_t;

endpackage

// ===== hw/rtl/cst_if.sv =====
// Handshake interfaces for the connection slot table: command words in,
// result words out and configuration writes. Depends on cst_pkg.
interface cst_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [cst_pkg::CMD_W-1:0]    command;
	logic [cst_pkg::SLOT_W-1:0]   slot;
	logic [cst_pkg::FIELD_KEY_W-1:0] player;
	logic [cst_pkg::FIELD_ST_W-1:0] new_state;
	modport source (output valid, command, slot, player, new_state, input ready);
	modport sink (input valid, command, slot, player, new_state, output ready);
endinterface

interface cst_res_if;
	logic                         valid;
	logic                         ready;
	logic [cst_pkg::STATUS_W-1:0] status;
	logic [cst_pkg::SLOT_W-1:0]   found_slot;
	logic [cst_pkg::LIVE_W-1:0]   live_count;
	modport source (output valid, status, found_slot, live_count, input ready);
	modport sink (input valid, status, found_slot, live_count, output ready);
endinterface

interface cst_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cst_pkg::CFG_IDX_W-1:0]  index;
	logic [cst_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cst_cell.sv =====
// One slot cell: holds the occupied mark, key and state of a slot and
// passes the scan token and running result to its neighbour. Depends on cst_pkg.
module cst_cell #(
	parameter int PLAYER_BITS = 32,
	parameter int STATE_BITS  = 3,
	parameter int IDX         = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cst_pkg::cst_cmd_t       cmd,
	input  logic [PLAYER_BITS-1:0]  key,
	input  logic [STATE_BITS-1:0]   nst,
	input  logic [STATE_BITS-1:0]   auth,
	input  cst_pkg::cst_link_t      link_in,
	output cst_pkg::cst_link_t      link_out
);
	import cst_pkg::*;

	logic                   occ_q;
	logic [PLAYER_BITS-1:0] player_q;
	logic [STATE_BITS-1:0]  state_q;
	cst_link_t              link_q;
	cst_link_t              link_d;
	logic                   is_add, is_find, in_range, is_tgt;
	logic                   match, take, tgt_hit;

	always_comb begin
		is_add   = (cmd.op == OP_ADD);
		is_find  = (cmd.op == OP_FIND) || (cmd.op == OP_FIND_OTHER);
		in_range = LIM_W'(IDX) < cmd.lim;
		is_tgt   = {{(SLOT_IDX_W-SLOT_W){1'b0}}, cmd.slot} == SLOT_IDX_W'(IDX);
		match    = is_find && occ_q && in_range && (player_q == key) &&
			(state_q == auth) && !((cmd.op == OP_FIND_OTHER) && is_tgt);
		take     = link_in.tok && !link_in.hit &&
			((is_add && !occ_q && in_range) || match);
		tgt_hit  = link_in.tok && is_tgt && occ_q;
		link_d   = link_in;
		if (take) begin
			link_d.hit = 1'b1;
			link_d.idx = SLOT_IDX_W'(IDX);
		end
		if (tgt_hit) begin
			link_d.tgt_occ = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= 1'b0;
			link_q <= '0;
		end else begin
			link_q <= link_d;
			if (take && is_add) begin
				occ_q <= 1'b1;
			end else if (tgt_hit && (cmd.op == OP_REMOVE)) begin
				occ_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_add) begin
			player_q <= key;
			state_q  <= nst;
		end else if (tgt_hit && (cmd.op == OP_BIND)) begin
			player_q <= key;
			state_q  <= auth;
		end else if (tgt_hit && (cmd.op == OP_SET_STATE)) begin
			state_q <= nst;
		end
	end

	assign link_out = link_q;

endmodule

// ===== hw/rtl/connection_slot_table_core.sv =====
// Connection slot table: top level, a chain of CAPACITY slot cells with the
// command, result and configuration logic. Depends on cst_pkg, cst_if, cst_cell.
//
// Usage: a command word (command, slot, player, new_state) is taken on the cmd
// channel and gives exactly one result word (status, found_slot, live_count) on
// the res channel. Registers table_size and authed_code are written through the
// cfg channel, which is always ready. The user must write them only while no
// command is in flight; the block itself does not enforce it. One command is
// handled at a time. A scan token walks the chain of slot cells, one cell per
// cycle, through the start register and each cell's link register. cmd is ready
// again in the same cycle as the result word becomes valid on res.
// When the receiver stalls the result waits in a holding register and then in
// the output register; cmd stays not ready until the result has moved on.
// Reset empties every slot, clears the live count and sets table_size to 16 and
// authed_code to 1; no command or result is in flight afterwards.
module connection_slot_table_core #(
	parameter int CAPACITY    = 16,
	parameter int PLAYER_BITS = 32,
	parameter int STATE_BITS  = 3
) (
	input logic clk,
	input logic arst_n,
	cst_cmd_if.sink   cmd,
	cst_res_if.source res,
	cst_cfg_if.sink   cfg
);
	import cst_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [TSIZE_W-1:0]     tsize_q;
	logic [AUTH_W-1:0]      authed_q;
	cst_cmd_t               cmd_q;
	logic [PLAYER_BITS-1:0] key_q;
	logic [STATE_BITS-1:0]  nst_q;
	logic                   busy_q, start_q, pend_q;
	logic [CNT_W-1:0]       count_q;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    out_status_q, hold_status_q;
	logic [SLOT_W-1:0]      out_found_q, hold_found_q;
	logic [LIVE_W-1:0]      out_live_q, hold_live_q;

	cst_link_t              link [CAPACITY+1];
	cst_link_t              tail;
	logic                   accept, out_free;
	logic [PLAYER_BITS+FIELD_KEY_W-1:0] key_ext;
	logic [STATE_BITS+FIELD_ST_W-1:0]   nst_ext;
	logic [STATE_BITS+AUTH_W-1:0]       auth_ext;
	logic [STATE_BITS-1:0]  auth;
	logic [LIM_W-1:0]       tsize_ext, lim;
	logic [CNT_W-1:0]       next_cnt;
	logic [CNT_W+LIVE_W-1:0] cnt_ext;
	logic [STATUS_W-1:0]    res_status;
	logic [SLOT_W-1:0]      res_found;

	assign accept   = cmd.valid && cmd.ready;
	assign cmd.ready = !busy_q;
	assign cfg.ready = 1'b1;
	assign out_free = !out_valid_q || res.ready;

	assign key_ext  = {{PLAYER_BITS{1'b0}}, cmd.player};
	assign nst_ext  = {{STATE_BITS{1'b0}}, cmd.new_state};
	assign auth_ext = {{STATE_BITS{1'b0}}, authed_q};
	assign auth     = auth_ext[STATE_BITS-1:0];
	assign tsize_ext = {{(LIM_W-TSIZE_W){1'b0}}, tsize_q};
	assign lim      = (tsize_ext > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : tsize_ext;

	assign link[0] = cst_link_t'{tok: start_q, default: '0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cst_cell #(
			.PLAYER_BITS(PLAYER_BITS),
			.STATE_BITS (STATE_BITS),
			.IDX        (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd_q),
			.key     (key_q),
			.nst     (nst_q),
			.auth    (auth),
			.link_in (link[i]),
			.link_out(link[i+1])
		);
	end

	assign tail = link[CAPACITY];

	always_comb begin
		next_cnt   = count_q;
		res_status = ST_OK;
		res_found  = '0;
		case (cmd_q.op)
			OP_ADD: begin
				if (tail.hit) begin
					next_cnt  = count_q + CNT_W'(1);
					res_found = tail.idx[SLOT_W-1:0];
				end else begin
					res_status = ST_FULL;
				end
			end
			OP_REMOVE: begin
				if (tail.tgt_occ) begin
					next_cnt = count_q - CNT_W'(1);
				end else begin
					res_status = ST_EMPTY;
				end
			end
			OP_BIND, OP_SET_STATE: begin
				if (!tail.tgt_occ) begin
					res_status = ST_EMPTY;
				end
			end
			OP_FIND, OP_FIND_OTHER: begin
				if (tail.hit) begin
					res_found = tail.idx[SLOT_W-1:0];
				end else begin
					res_status = ST_NOMATCH;
				end
			end
			default: begin
			end
		endcase
		cnt_ext = {{LIVE_W{1'b0}}, next_cnt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q  <= TSIZE_W'(16);
			authed_q <= AUTH_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TABLE_SIZE:  tsize_q  <= cfg.data[TSIZE_W-1:0];
				REG_AUTHED_CODE: authed_q <= cfg.data[AUTH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op   <= cmd.command;
			cmd_q.slot <= cmd.slot;
			cmd_q.lim  <= lim;
			key_q      <= key_ext[PLAYER_BITS-1:0];
			nst_q      <= nst_ext[STATE_BITS-1:0];
		end
		if (tail.tok && !out_free) begin
			hold_status_q <= res_status;
			hold_found_q  <= res_found;
			hold_live_q   <= cnt_ext[LIVE_W-1:0];
		end
		if (tail.tok && out_free) begin
			out_status_q <= res_status;
			out_found_q  <= res_found;
			out_live_q   <= cnt_ext[LIVE_W-1:0];
		end else if (pend_q && out_free) begin
			out_status_q <= hold_status_q;
			out_found_q  <= hold_found_q;
			out_live_q   <= hold_live_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			pend_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end
			if (tail.tok) begin
				count_q <= next_cnt;
			end
			if (tail.tok && !out_free) begin
				pend_q <= 1'b1;
			end
			if ((tail.tok || pend_q) && out_free) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
				busy_q      <= 1'b0;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid      = out_valid_q;
	assign res.status     = out_status_q;
	assign res.found_slot = out_found_q;
	assign res.live_count = out_live_q;

endmodule
